// ===== hw/rtl/drpu_pkg.sv =====
// Package for the dead-reckoning position update block: types, constants and functions
package drpu_pkg;

	localparam int AngleBits    = 16;
	localparam int CordicStages = 16;
	localparam int TableLen     = 24;
	localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;
	localparam int StageW       = $clog2(TableLen + 1);
	localparam int TrigW        = 34;
	localparam logic signed [TrigW-1:0] CordicK = 34'sd652032874;

	typedef enum logic [0:0] {
		REG_START_X = 1'b0,
		REG_START_Y = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               track_select;
		logic [15:0]        heading;
		logic signed [15:0] speed;
		logic [31:0]        step_start;
		logic [31:0]        step_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [31:0] data;
	} cfg_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_VEL,
		ST_DIST,
		ST_ACC
	} state_t;

	// arctangent table, 2^32 per full turn
	function automatic logic [31:0] atan_turn(input logic [StageW-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/drpu_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle
module drpu_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [31:0]                          angle,
	output logic                                 done,
	output logic signed [drpu_pkg::TrigW-1:0]    cos_out,
	output logic signed [drpu_pkg::TrigW-1:0]    sin_out
);

	logic signed [drpu_pkg::TrigW-1:0] x_q, y_q;
	logic signed [32:0]                z_q;
	logic [drpu_pkg::StageW-1:0]       i_q;
	logic                              busy_q, neg_q;
	logic                              done_q;
	logic                              neg_in;
	logic                              last;
	logic signed [drpu_pkg::TrigW-1:0] xs, ys;
	logic signed [32:0]                at;

	assign neg_in = angle[31] ^ angle[30];
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({1'b0, drpu_pkg::atan_turn(i_q)});
	assign last = (i_q == drpu_pkg::StageW'(drpu_pkg::NumStages - 1));

	// micro-rotation and stage counter; done follows the last rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (last) busy_q <= 1'b0;
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= drpu_pkg::CordicK;
			y_q   <= '0;
			neg_q <= neg_in;
			z_q   <= 33'(signed'(neg_in ? angle + 32'h80000000 : angle));
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_out = neg_q ? -x_q : x_q;
	assign sin_out = neg_q ? -y_q : y_q;

endmodule

// ===== hw/rtl/drpu_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add
module drpu_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] a,
	input  logic signed [32:0] b,
	output logic               done,
	output logic signed [80:0] prod
);

	logic signed [80:0] acc_q;
	logic [32:0]        b_q;
	logic signed [80:0] a_q;
	logic [5:0]         cnt_q;
	logic               busy_q;

	// top bit of b carries negative weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 6'd32) busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= 81'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= (cnt_q == 6'd32) ? acc_q - a_q : acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = busy_q && (cnt_q == 6'd32);
	assign prod = (b_q[0] && done) ? acc_q - a_q : acc_q;

endmodule

// ===== hw/rtl/dead_reckoning_position_update.sv =====
// Top level of the dead-reckoning position update block
// Two tracks, selected per item, each hold a saturating Q16.16 x and y. An input
// transfer runs a 16-stage CORDIC on the heading, then scales cos and sin by speed and step
// time in one shared bit-serial multiplier and adds the distances to the selected track.
// The result follows the CORDIC rotations, four serial products (velocity, then distance, per
// axis) in the bit-serial multiplier and one accumulation step per axis. Input is ready again
// in the same cycle that the result becomes valid, so a new item is taken only once the last
// result is registered; a result still waiting in the output register only holds the next item at
// its final accumulation. Sums saturate at the signed 32-bit range. A configuration write loads
// the start register and that coordinate of both tracks, and is taken only while idle.
module dead_reckoning_position_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  drpu_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output drpu_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  drpu_pkg::cfg_item_t cfg_data
);

	drpu_pkg::state_t state_q, state_d;
	drpu_pkg::in_item_t item_q;
	logic signed [31:0] start_x_q, start_y_q;
	logic signed [31:0] px_q [2];
	logic signed [31:0] py_q [2];
	logic               axis_q;
	logic               sat_x_q;
	logic               out_valid_q;
	drpu_pkg::out_item_t out_q;

	logic               cor_start, cor_done;
	logic [31:0]        angle;
	logic signed [drpu_pkg::TrigW-1:0] cos_w, sin_w;
	logic               mul_start, mul_done;
	logic signed [47:0] mul_a;
	logic signed [32:0] mul_b, dt;
	logic signed [80:0] prod;
	logic signed [47:0] vel;
	logic signed [48:0] step_dist;
	logic signed [33:0] sum_x, sum_y;
	logic [31:0]        nx, ny;
	logic               clip_x, clip_y;
	logic               sel;
	logic               out_free;

	assign angle = 32'(in_data.heading[drpu_pkg::AngleBits-1:0]) << (32 - drpu_pkg::AngleBits);
	assign dt    = $signed({1'b0, item_q.step_end}) - $signed({1'b0, item_q.step_start});
	assign sel   = item_q.track_select;
	assign out_free = !out_valid_q || out_ready;

	drpu_cordic u_cordic (
		.clk, .arst_n, .start(cor_start), .angle,
		.done(cor_done), .cos_out(cos_w), .sin_out(sin_w)
	);

	drpu_serial_mul u_mul (
		.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod
	);

	// operand selection for the shared multiplier; the distance product starts from the
	// velocity as it leaves the multiplier, the CORDIC outputs hold until the next item
	always_comb begin
		if (state_q == drpu_pkg::ST_VEL) begin
			mul_a = vel;
			mul_b = dt;
		end else begin
			mul_a = 48'((state_q == drpu_pkg::ST_ACC) ? sin_w : cos_w);
			mul_b = 33'(item_q.speed);
		end
	end

	assign vel       = 48'(prod >>> 22);
	assign step_dist = 49'(prod >>> 12);

	// saturating accumulation; distances are bounded well inside 49 bits
	always_comb begin
		logic signed [49:0] tx, ty;
		tx = 50'(px_q[sel]) + 50'(step_dist);
		ty = 50'(py_q[sel]) + 50'(step_dist);
		clip_x = (tx > 50'sd2147483647) || (tx < -50'sd2147483648);
		clip_y = (ty > 50'sd2147483647) || (ty < -50'sd2147483648);
		nx = tx > 50'sd2147483647 ? 32'h7FFFFFFF : (tx < -50'sd2147483648 ? 32'h80000000 : tx[31:0]);
		ny = ty > 50'sd2147483647 ? 32'h7FFFFFFF : (ty < -50'sd2147483648 ? 32'h80000000 : ty[31:0]);
	end
	assign sum_x = 34'(nx);
	assign sum_y = 34'(ny);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drpu_pkg::ST_IDLE:   if (in_valid) state_d = drpu_pkg::ST_CORDIC;
			drpu_pkg::ST_CORDIC: if (cor_done) state_d = drpu_pkg::ST_VEL;
			drpu_pkg::ST_VEL:    if (mul_done) state_d = drpu_pkg::ST_DIST;
			drpu_pkg::ST_DIST:   if (mul_done) state_d = drpu_pkg::ST_ACC;
			drpu_pkg::ST_ACC: begin
				if (!axis_q) state_d = drpu_pkg::ST_VEL;
				else if (out_free) state_d = drpu_pkg::ST_IDLE;
			end
			default:             state_d = drpu_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == drpu_pkg::ST_IDLE);
		cfg_ready = (state_q == drpu_pkg::ST_IDLE);
		cor_start = (state_q == drpu_pkg::ST_IDLE) && in_valid;
		mul_start = ((state_q == drpu_pkg::ST_CORDIC) && cor_done) ||
			((state_q == drpu_pkg::ST_VEL) && mul_done) ||
			((state_q == drpu_pkg::ST_ACC) && !axis_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drpu_pkg::ST_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			px_q[0]     <= '0;
			px_q[1]     <= '0;
			py_q[0]     <= '0;
			py_q[1]     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == drpu_pkg::ST_ACC && axis_q && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_data.index == {1'b0, drpu_pkg::REG_START_X}) begin
					start_x_q <= cfg_data.data;
					px_q[0] <= cfg_data.data;
					px_q[1] <= cfg_data.data;
				end else if (cfg_data.index == {1'b0, drpu_pkg::REG_START_Y}) begin
					start_y_q <= cfg_data.data;
					py_q[0] <= cfg_data.data;
					py_q[1] <= cfg_data.data;
				end
			end
			if (cor_start) axis_q <= 1'b0;
			if (state_q == drpu_pkg::ST_ACC) begin
				axis_q <= 1'b1;
				if (!axis_q) px_q[sel] <= sum_x[31:0];
				else if (out_free) py_q[sel] <= sum_y[31:0];
			end
		end
	end

	// item capture and result register
	always_ff @(posedge clk) begin
		if (cor_start) item_q <= in_data;
		if (state_q == drpu_pkg::ST_ACC && !axis_q) sat_x_q <= clip_x;
		if (state_q == drpu_pkg::ST_ACC && axis_q && out_free) begin
			out_q.pos_x     <= px_q[sel];
			out_q.pos_y     <= ny;
			out_q.saturated <= sat_x_q | clip_y;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a waiting result holds still until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result changed");

	// start registers only change through the configuration port
	a_start_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_valid && cfg_ready) |-> $stable(start_x_q) && $stable(start_y_q))
		else $error("start register changed without write");

	// a result follows the second accumulation step
	a_out_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == drpu_pkg::ST_ACC && axis_q))
		else $error("result raised out of sequence");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the dead-reckoning position update block
`timescale 1ns / 100ps

module tb_top;

	localparam int MaxCycles = 3000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	drpu_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	drpu_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	drpu_pkg::cfg_item_t cfg_data;

	dead_reckoning_position_update DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state: both tracks
	logic signed [31:0] trk_x [2];
	logic signed [31:0] trk_y [2];

	drpu_pkg::in_item_t  pending_steps [$];
	drpu_pkg::out_item_t expected_pos [$];
	int        mismatches;
	int        cycle_count;
	int        sent_count;
	int        done_count;

	// per-item random delays
	int        send_wait;
	int        recv_wait;

	// config channel handshake from the initial block
	logic      cfg_req;
	drpu_pkg::cfg_item_t cfg_req_data;
	logic      cfg_done;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	// CORDIC rotation giving cos and sin of a turn angle in Q2.30
	task automatic heading_trig(input logic [31:0] angle, output longint c, output longint s);
		logic   neg;
		longint x, y, z, nx;
		logic [31:0] a;
		longint tab [24];
		tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		neg = angle[31] ^ angle[30];
		a = neg ? angle + 32'h80000000 : angle;
		x = 652032874;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < drpu_pkg::NumStages; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z = z - tab[i];
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z = z + tab[i];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic logic signed [31:0] clip_add(input longint acc, input longint d,
			inout logic clipped);
		longint r;
		r = acc + d;
		if (r > 64'sd2147483647) begin
			clipped = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (r < -64'sd2147483648) begin
			clipped = 1'b1;
			return 32'sh80000000;
		end
		return r[31:0];
	endfunction

	// integrate one step into the predicted track and queue the expected position
	task automatic predict_position(input drpu_pkg::in_item_t it);
		longint c, s, spd, dt, vx, vy;
		logic [31:0] angle;
		logic clipped;
		int t;
		drpu_pkg::out_item_t r;
		t = it.track_select;
		angle = 32'(it.heading[drpu_pkg::AngleBits-1:0]) << (32 - drpu_pkg::AngleBits);
		heading_trig(angle, c, s);
		spd = it.speed;
		dt = longint'({32'b0, it.step_end}) - longint'({32'b0, it.step_start});
		vx = floor_shift(c * spd, 22);
		vy = floor_shift(s * spd, 22);
		clipped = 1'b0;
		trk_x[t] = clip_add(trk_x[t], floor_shift(vx * dt, 12), clipped);
		trk_y[t] = clip_add(trk_y[t], floor_shift(vy * dt, 12), clipped);
		r.pos_x = trk_x[t];
		r.pos_y = trk_y[t];
		r.saturated = clipped;
		expected_pos.insert(expected_pos.size(), r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		mismatches++;
	endtask

	// driver: step items from the queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_wait <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (send_wait > 0) begin
			in_valid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (pending_steps.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= pending_steps.pop_front();
			send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// predict on each accepted transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_position(in_data);
	end

	// config driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			cfg_done <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_valid <= 1'b0;
			cfg_done <= 1'b1;
			if (cfg_data.index == 2'(drpu_pkg::REG_START_X)) begin
				trk_x[0] = cfg_data.data;
				trk_x[1] = cfg_data.data;
			end else if (cfg_data.index == 2'(drpu_pkg::REG_START_Y)) begin
				trk_y[0] = cfg_data.data;
				trk_y[1] = cfg_data.data;
			end
		end else if (cfg_req && !cfg_valid && !cfg_done) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_req_data;
		end else if (!cfg_req) begin
			cfg_done <= 1'b0;
		end
	end

	// monitor: random back-pressure and field checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pos.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					drpu_pkg::out_item_t e;
					e = expected_pos.pop_front();
					if (out_data.pos_x !== e.pos_x)
						report_mismatch("pos_x", out_data.pos_x, e.pos_x);
					if (out_data.pos_y !== e.pos_y)
						report_mismatch("pos_y", out_data.pos_y, e.pos_y);
					if (out_data.saturated !== e.saturated)
						report_mismatch("saturated", out_data.saturated, e.saturated);
				end
				done_count++;
				recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MaxCycles) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic drpu_pkg::in_item_t make_step(input logic sel, input logic [15:0] hd,
			input logic [15:0] spd, input logic [31:0] t0, input logic [31:0] t1);
		drpu_pkg::in_item_t it;
		it.track_select = sel;
		it.heading = hd;
		it.speed = spd;
		it.step_start = t0;
		it.step_end = t1;
		return it;
	endfunction

	// mostly short steps, sometimes full-range timestamps
	function automatic drpu_pkg::in_item_t random_step();
		logic [31:0] t0;
		logic [31:0] t1;
		t0 = $urandom;
		case ($urandom_range(0, 9))
			0: t1 = $urandom;
			1: t1 = t0 - $urandom_range(0, 8192);
			default: t1 = t0 + $urandom_range(0, 8192);
		endcase
		return make_step(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), t0, t1);
	endfunction

	// hand one item to the driver
	task automatic queue_step(input drpu_pkg::in_item_t it);
		pending_steps.insert(pending_steps.size(), it);
		sent_count++;
	endtask

	task automatic wait_idle();
		while (done_count != sent_count)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input drpu_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_req_data.index = 2'(idx);
		cfg_req_data.data = val;
		cfg_req = 1'b1;
		@(posedge clk);
		while (!cfg_done) @(posedge clk);
		cfg_req = 1'b0;
		@(posedge clk);
		while (cfg_done) @(posedge clk);
	endtask

	initial begin
		logic [31:0] sx [4];
		logic [31:0] sy [4];
		sx = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0};
		sy = '{32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0};
		mismatches = 0;
		sent_count = 0;
		done_count = 0;
		cfg_req = 1'b0;
		cfg_req_data = '0;
		trk_x = '{0, 0};
		trk_y = '{0, 0};
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme fields, each quadrant edge, backward steps, saturation
		queue_step(make_step(1'b0, 16'h0000, 16'h7FFF, 32'd0, 32'd4096));
		queue_step(make_step(1'b1, 16'h4000, 16'h8000, 32'd0, 32'd4096));
		queue_step(make_step(1'b0, 16'h8000, 16'h0100, 32'd100, 32'd50));
		queue_step(make_step(1'b1, 16'hC000, 16'h0100, 32'd0, 32'd0));
		queue_step(make_step(1'b0, 16'h3FFF, 16'hFFFF, 32'd0, 32'd1));
		queue_step(make_step(1'b1, 16'hBFFF, 16'h0001, 32'd1, 32'd0));
		queue_step(make_step(1'b0, 16'hFFFF, 16'h7FFF, 32'd0, 32'hFFFFFFFF));
		queue_step(make_step(1'b0, 16'hFFFF, 16'h7FFF, 32'd0, 32'hFFFFFFFF));
		queue_step(make_step(1'b1, 16'h2000, 16'h8000, 32'hFFFFFFFF, 32'd0));
		queue_step(make_step(1'b1, 16'h6000, 16'h8000, 32'hFFFFFFFF, 32'd0));
		queue_step(make_step(1'b0, 16'hA000, 16'h7FFF, 32'hFFFFFFFF, 32'd0));
		queue_step(make_step(1'b1, 16'hE000, 16'h7FFF, 32'd0, 32'hFFFFFFFF));
		wait_idle();

		// random phases over several start settings; the sender stalls while more than four steps wait
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(drpu_pkg::REG_START_X, (ph == 3) ? $urandom : sx[ph]);
			write_reg(drpu_pkg::REG_START_Y, (ph == 3) ? $urandom : sy[ph]);
			for (int i = 0; i < 435; i++) begin
				if (i == 200)
					wait_idle();
				queue_step(random_step());
				while (pending_steps.size() > 4) @(posedge clk);
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== dead_reckoning_position_update.f =====
hw/rtl/drpu_pkg.sv
hw/rtl/drpu_cordic.sv
hw/rtl/drpu_serial_mul.sv
hw/rtl/dead_reckoning_position_update.sv
tb/tb_top.sv
